/* sv/orpt_pkg.sv */
// Package for the ordered ring playlist table: field widths, codes, FSM states
// and the command bundle from controller to datapath. No dependencies.
`timescale 1ns / 1ps

package orpt_pkg;

  // Field widths fixed by the stream format
  localparam int MODE_W      = 3;
  localparam int SKEY_W      = 16;
  localparam int POS_W       = 5;
  localparam int STATUS_W    = 3;
  localparam int PKEY_W      = 16;
  localparam int PIDX_W      = 4;
  localparam int ECNT_W      = 5;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  // Default sizing
  localparam int CAPACITY_DEF  = 16;
  localparam int KEY_WIDTH_DEF = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 3'd0,
    MODE_DELETE = 3'd1,
    MODE_NEXT   = 3'd2,
    MODE_PREV   = 3'd3,
    MODE_AT_POS = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // latch command, compare key against all cells
    logic commit;   // apply operation, load result register
  } ctrl_cmd_t;

endpackage

/* sv/orpt_ctrl.sv */
// Controller for the ordered ring playlist table: capture/execute sequencing
// and the result valid flag. Depends on orpt_pkg.
`timescale 1ns / 1ps

module orpt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output orpt_pkg::ctrl_cmd_t cmd
);
  import orpt_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    in_tready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    state_nxt   = state_r;
    unique case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        // wait here only while an old result still sits unclaimed
        cmd.commit = !out_valid_r || out_tready;
        if (cmd.commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cmd.commit)      out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
  end

  assign out_tvalid = out_valid_r;

endmodule

/* sv/orpt_dpath.sv */
// Datapath for the ordered ring playlist table: row of key cells with
// per-cell compare and shift, count, play cursor, result register. Uses orpt_pkg.
`timescale 1ns / 1ps

module orpt_dpath #(
  parameter int CAPACITY  = orpt_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = orpt_pkg::KEY_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  orpt_pkg::ctrl_cmd_t          cmd,
  input  logic [orpt_pkg::MODE_W-1:0]  in_mode,
  input  logic [orpt_pkg::SKEY_W-1:0]  in_song_key,
  input  logic [orpt_pkg::POS_W-1:0]   in_position,
  output logic [orpt_pkg::STATUS_W-1:0] out_status,
  output logic [orpt_pkg::PKEY_W-1:0]  out_played_key,
  output logic [orpt_pkg::PIDX_W-1:0]  out_played_index,
  output logic [orpt_pkg::ECNT_W-1:0]  out_entry_count
);
  import orpt_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CUR_W = $clog2(CAPACITY + 2);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CAPACITY-1:0] ALL_ONES = {CAPACITY{1'b1}};

  // state
  logic [KEY_WIDTH-1:0] cell_r [CAPACITY];
  logic [KEY_WIDTH-1:0] cell_nxt [CAPACITY];
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CUR_W-1:0]     cursor_r, cursor_nxt;

  // captured command
  logic [MODE_W-1:0]    mode_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [POS_W-1:0]     pos_r;
  logic [CAPACITY-1:0]  match_r, match_nxt;

  // result register
  logic [STATUS_W-1:0]  o_status_r, o_status_nxt;
  logic [PKEY_W-1:0]    o_key_r, o_key_nxt;
  logic [PIDX_W-1:0]    o_idx_r, o_idx_nxt;
  logic [ECNT_W-1:0]    o_count_r, o_count_nxt;

  logic [31:0]          in_key32;
  logic [KEY_WIDTH-1:0] in_key;
  logic [CAPACITY-1:0]  shift_v;
  logic [CUR_W-1:0]     cur_eff, bwd_w;
  logic [CMP_W-1:0]     pos_x, cnt_x;
  logic [31:0]          pos_m1, key32, idx32, cnt32;
  logic [IDX_W-1:0]     rd_idx;
  logic [KEY_WIDTH-1:0] rd_key;
  logic                 play_ok;

  // incoming key kept to KEY_WIDTH bits
  assign in_key32 = 32'(in_song_key);
  assign in_key   = in_key32[KEY_WIDTH-1:0];

  // per-cell compare, only over occupied cells
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_nxt[i] = (CNT_W'(i) < count_r) && (cell_r[i] == in_key);
    end
  end

  // cell i takes the key of cell i+1 when the first match lies at or below it
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      shift_v[i] = |(match_r & (ALL_ONES >> (CAPACITY - 1 - i)));
    end
  end

  // cursor falls back to 1 once past the count
  assign cur_eff = (cursor_r > CUR_W'(count_r)) ? CUR_W'(1) : cursor_r;
  assign bwd_w   = (cur_eff == CUR_W'(1)) ? '0
                 : CUR_W'(count_r) - cur_eff + CUR_W'(1);

  assign pos_x  = CMP_W'(pos_r);
  assign cnt_x  = CMP_W'(count_r);
  assign pos_m1 = 32'(pos_r) - 32'd1;

  always_comb begin
    rd_idx = '0;
    unique case (mode_r)
      MODE_NEXT: rd_idx = cur_eff[IDX_W-1:0] - IDX_W'(1);
      MODE_PREV: rd_idx = bwd_w[IDX_W-1:0];
      default:   rd_idx = pos_m1[IDX_W-1:0];
    endcase
  end

  assign rd_key = cell_r[rd_idx];
  assign key32  = 32'(rd_key);
  assign idx32  = 32'(rd_idx);
  assign cnt32  = 32'(count_nxt);

  always_comb begin
    cell_nxt     = cell_r;
    count_nxt    = count_r;
    cursor_nxt   = cursor_r;
    o_status_nxt = ST_OK;
    play_ok      = 1'b0;
    unique case (mode_r)
      MODE_APPEND: begin
        if (count_r == CNT_W'(CAPACITY)) begin
          o_status_nxt = ST_FULL;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (CNT_W'(i) == count_r) cell_nxt[i] = key_r;
          end
          count_nxt = count_r + CNT_W'(1);
        end
      end
      MODE_DELETE: begin
        if (count_r == '0) begin
          o_status_nxt = ST_EMPTY;
        end else if (!(|match_r)) begin
          o_status_nxt = ST_NOT_FOUND;
        end else begin
          for (int i = 0; i < CAPACITY - 1; i++) begin
            if (shift_v[i]) cell_nxt[i] = cell_r[i+1];
          end
          count_nxt = count_r - CNT_W'(1);
        end
      end
      MODE_NEXT, MODE_PREV: begin
        cursor_nxt = cur_eff + CUR_W'(1);
        if (count_r == '0) o_status_nxt = ST_EMPTY;
        else               play_ok      = 1'b1;
      end
      MODE_AT_POS: begin
        if (count_r == '0)                        o_status_nxt = ST_EMPTY;
        else if (pos_r == '0 || pos_x > cnt_x)    o_status_nxt = ST_RANGE;
        else                                      play_ok      = 1'b1;
      end
      default: o_status_nxt = ST_OK;  // unused modes do nothing
    endcase

    o_key_nxt   = play_ok ? key32[PKEY_W-1:0] : '0;
    o_idx_nxt   = play_ok ? idx32[PIDX_W-1:0] : '0;
    o_count_nxt = cnt32[ECNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      cursor_r <= CUR_W'(1);
    end else if (cmd.commit) begin
      count_r  <= count_nxt;
      cursor_r <= cursor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= in_mode;
      key_r   <= in_key;
      pos_r   <= in_position;
      match_r <= match_nxt;
    end
    if (cmd.commit) begin
      cell_r     <= cell_nxt;
      o_status_r <= o_status_nxt;
      o_key_r    <= o_key_nxt;
      o_idx_r    <= o_idx_nxt;
      o_count_r  <= o_count_nxt;
    end
  end

  assign out_status       = o_status_r;
  assign out_played_key   = o_key_r;
  assign out_played_index = o_idx_r;
  assign out_entry_count  = o_count_r;

endmodule

/* sv/ordered_ring_playlist_table.sv */
// Top level of the ordered ring playlist table: stream ports, field packing,
// controller and datapath. Depends on orpt_pkg, orpt_ctrl, orpt_dpath.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_*): one beat is one command. in_tuser carries the mode
//   (append, delete, play next, play previous, play at position); in_tdata
//   carries the song key and the 1-based position.
//   Output channel (out_*): exactly one beat per command, in command order,
//   with the status code on out_tuser and the played key, its index from
//   the head and the entry count after the command on out_tdata.
//   Timing: a command is captured when it is accepted; its result is loaded
//   into the output register when the execute state commits. The controller
//   runs capture (parallel key compare in every cell) then execute (shift or
//   write of the cells, cursor and count update), and in_tready stays low
//   while the controller is in execute.
//   Stall: the result sits in an output register; the next command is
//   still taken while it waits, and only its execute cycle holds until the
//   receiver takes the old result. Nothing is dropped or repeated.
//   Reset: synchronous, active low; the list empties, the play cursor goes
//   to one, no result is pending. Key cells are not cleared: only occupied
//   cells are ever read, so no clearing pass is needed.

module ordered_ring_playlist_table #(
  parameter int CAPACITY  = orpt_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = orpt_pkg::KEY_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [orpt_pkg::IN_TDATA_W-1:0]     in_tdata,   // [15:0] song_key, [20:16] position
  input  logic [orpt_pkg::MODE_W-1:0]         in_tuser,   // [2:0] mode
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [orpt_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [15:0] played_key,
                                                          // [19:16] played_index,
                                                          // [24:20] entry_count
  output logic [orpt_pkg::STATUS_W-1:0]       out_tuser   // [2:0] status
);
  import orpt_pkg::*;

  ctrl_cmd_t            cmd;
  logic [PKEY_W-1:0]    played_key;
  logic [PIDX_W-1:0]    played_index;
  logic [ECNT_W-1:0]    entry_count;

  orpt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  orpt_dpath #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_mode          (in_tuser),
    .in_song_key      (in_tdata[SKEY_W-1:0]),
    .in_position      (in_tdata[SKEY_W+POS_W-1:SKEY_W]),
    .out_status       (out_tuser),
    .out_played_key   (played_key),
    .out_played_index (played_index),
    .out_entry_count  (entry_count)
  );

  // pad to whole bytes
  assign out_tdata = {{(OUT_TDATA_W-PKEY_W-PIDX_W-ECNT_W){1'b0}},
                      entry_count, played_index, played_key};

endmodule

/* sv/orpt_checker.sv */
// Port-level checks for the ordered ring playlist table, bound to the top
// level. Depends on orpt_pkg and ordered_ring_playlist_table.
`timescale 1ns / 1ps

module orpt_checker #(
  parameter int CAPACITY = orpt_pkg::CAPACITY_DEF
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [orpt_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [orpt_pkg::STATUS_W-1:0]    out_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready
);
  import orpt_pkg::*;

  // a stalled result beat holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // each command owns the execute cycle after its capture
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken in the execute cycle");

  // a full report only comes with the list at capacity
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_FULL |-> out_tdata[24:20] == ECNT_W'(CAPACITY))
    else $error("full status with list below capacity");

  // an empty report only comes with no entries
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_EMPTY |-> out_tdata[24:20] == '0)
    else $error("empty status with entries present");

endmodule

bind ordered_ring_playlist_table orpt_checker #(.CAPACITY(CAPACITY)) u_orpt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
